FILE: sv/dsdd_pkg.sv
package dsdd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int ACC_W   = 7;
	localparam int POS_W   = 4;
	localparam int YY_W    = 15;
	localparam int ERA_W   = 7;
	localparam int YOE_W   = 9;
	localparam int DOY_W   = 9;
	localparam int NUM_W   = 24;
	localparam int GAP_W   = 22;
	localparam int IDX_W   = 2;
	localparam int CFG_W   = 14;

	localparam logic [7:0] SEP_DASH   = 8'h2D;
	localparam logic [7:0] SEP_SLASH  = 8'h2F;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	localparam logic [POS_W-1:0] LINE_LENGTH = 4'd10;
	localparam logic [POS_W-1:0] POS_SEP_A   = 4'd4;
	localparam logic [POS_W-1:0] POS_SEP_B   = 4'd7;

	localparam logic [IDX_W-1:0] REG_YEAR  = 2'd0;
	localparam logic [IDX_W-1:0] REG_MONTH = 2'd1;
	localparam logic [IDX_W-1:0] REG_DAY   = 2'd2;

	localparam logic [YEAR_W-1:0]  RESET_YEAR  = 14'd2004;
	localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd3;
	localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;

	localparam logic [MONTH_W-1:0] MONTHS_PER_YEAR = 4'd12;
	localparam logic [YY_W-1:0]    YEAR_BIAS       = 15'd400;
	localparam logic [NUM_W-1:0]   ERA_DAYS        = 24'd146097;
	localparam logic [NUM_W-1:0]   YEAR_DAYS       = 24'd365;

	typedef struct packed {
		logic               ok;
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [POS_W-1:0]   pos;
	} line_t;

	// floor(x / 25) for x below 4096
	function automatic logic [7:0] div25(input logic [11:0] x);
		logic [22:0] p;
		p = 23'(x) * 23'd1311;
		return p[22:15];
	endfunction

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W-1:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
			4'd2: r = leap ? 5'd29 : 5'd28;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// month counted from march
	function automatic logic [MONTH_W-1:0] march_index(input logic [MONTH_W-1:0] m);
		logic [MONTH_W-1:0] r;
		if (m >= 4'd3)
			r = m - 4'd3;
		else
			r = m + 4'd9;
		return r;
	endfunction

	// days before the first of the month, year starting in march
	function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] mp);
		logic [DOY_W-1:0] r;
		case (mp)
			4'd0:  r = 9'd0;
			4'd1:  r = 9'd31;
			4'd2:  r = 9'd61;
			4'd3:  r = 9'd92;
			4'd4:  r = 9'd122;
			4'd5:  r = 9'd153;
			4'd6:  r = 9'd184;
			4'd7:  r = 9'd214;
			4'd8:  r = 9'd245;
			4'd9:  r = 9'd275;
			4'd10: r = 9'd306;
			4'd11: r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/dsdd_line_parser.sv
module dsdd_line_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take_char,
	input  logic          take_end,
	input  logic [7:0]    character,
	output dsdd_pkg::line_t line
);
	import dsdd_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [YEAR_W-1:0] year_q;
	logic [ACC_W-1:0]  month_q;
	logic [ACC_W-1:0]  day_q;
	logic [7:0]        sep_q;
	logic              err_q;

	logic              is_digit;
	logic [3:0]        dv;
	logic [7:0]        q100;
	logic [YEAR_W-1:0] hund;
	logic              leap;
	logic [DAY_W-1:0]  lim;
	logic              fmt_ok;
	logic              month_ok;
	logic              day_ok;

	assign is_digit = (character >= DIGIT_ZERO) && (character <= DIGIT_NINE);
	assign dv       = character[3:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			sep_q   <= '0;
			err_q   <= 1'b0;
		end else if (take_end) begin
			pos_q   <= '0;
			year_q  <= '0;
			month_q <= '0;
			day_q   <= '0;
			sep_q   <= '0;
			err_q   <= 1'b0;
		end else if (take_char) begin
			if (pos_q >= LINE_LENGTH) begin
				err_q <= 1'b1;
			end else begin
				if (pos_q == POS_SEP_A) begin
					sep_q <= character;
				end else if (pos_q == POS_SEP_B) begin
					if (character != sep_q)
						err_q <= 1'b1;
				end else if (!is_digit) begin
					err_q <= 1'b1;
				end else if (pos_q < POS_SEP_A) begin
					year_q <= year_q * 14'd10 + {10'd0, dv};
				end else if (pos_q < POS_SEP_B) begin
					month_q <= month_q * 7'd10 + {3'd0, dv};
				end else begin
					day_q <= day_q * 7'd10 + {3'd0, dv};
				end
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// gregorian leap rule through the quotient by 100
	assign q100 = div25(year_q[13:2]);
	assign hund = 14'(q100) * 14'd100;
	assign leap = (year_q[1:0] == 2'd0) && ((year_q != hund) || (q100[1:0] == 2'd0));
	assign lim  = month_days(month_q[3:0], leap);

	assign fmt_ok   = (pos_q == LINE_LENGTH) && !err_q &&
	                  ((sep_q == SEP_DASH) || (sep_q == SEP_SLASH));
	assign month_ok = (month_q >= 7'd1) && (month_q <= 7'(MONTHS_PER_YEAR));
	assign day_ok   = (day_q >= 7'd1) && (day_q <= 7'(lim));

	assign line.ok    = fmt_ok && month_ok && day_ok;
	assign line.year  = year_q;
	assign line.month = month_q[3:0];
	assign line.day   = day_q[4:0];
	assign line.pos   = pos_q;

endmodule

FILE: sv/dsdd_day_count.sv
module dsdd_day_count (
	input  logic                         clk,
	input  logic                         en_a,
	input  logic                         en_b,
	input  logic [dsdd_pkg::YY_W-1:0]    yy,
	input  logic [dsdd_pkg::MONTH_W-1:0] mp,
	input  logic [dsdd_pkg::DAY_W-1:0]   day,
	output logic [dsdd_pkg::NUM_W-1:0]   num_s3
);
	import dsdd_pkg::*;

	logic [ERA_W-1:0] era_c;
	logic [YOE_W-1:0] yoe_c;
	logic [DOY_W-1:0] dsum_c;
	logic [7:0]       q400;

	logic [ERA_W-1:0] era_s2;
	logic [YOE_W-1:0] yoe_s2;
	logic [DOY_W-1:0] dsum_s2;
	logic [1:0]       cent;

	// era by 400-year cycles
	assign q400   = div25({1'b0, yy[14:4]});
	assign era_c  = q400[6:0];
	assign yoe_c  = 9'(yy - 15'(era_c) * 15'd400);
	assign dsum_c = cum_days(mp) + {4'd0, day};

	always_ff @(posedge clk) begin
		if (en_a) begin
			era_s2  <= era_c;
			yoe_s2  <= yoe_c;
			dsum_s2 <= dsum_c;
		end
	end

	always_comb begin
		if (yoe_s2 >= 9'd300)
			cent = 2'd3;
		else if (yoe_s2 >= 9'd200)
			cent = 2'd2;
		else if (yoe_s2 >= 9'd100)
			cent = 2'd1;
		else
			cent = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (en_b)
			num_s3 <= 24'(era_s2) * ERA_DAYS + 24'(yoe_s2) * YEAR_DAYS
			        + 24'(yoe_s2[8:2]) - 24'(cent) + 24'(dsum_s2) - 24'd1;
	end

endmodule

FILE: sv/date_string_day_difference.sv
// a line-end transaction's result passes stages s1, s2, s3 and the output register
// throughput: one transaction per cycle, characters and line ends alike
// the rate is set by the four-register day-count pipeline, stalled only by result_ready
// reference writes reach the compare stage through the ref and day-count registers
// reset: reference date 2004-03-01, line state cleared, pipeline empty
module date_string_day_difference (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  logic [7:0]                   character,
	input  logic                         line_end,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic                         date_valid,
	output logic [dsdd_pkg::GAP_W-1:0]   days_since_reference,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [dsdd_pkg::IDX_W-1:0]   cfg_index,
	input  logic [dsdd_pkg::CFG_W-1:0]   cfg_data
);
	import dsdd_pkg::*;

	logic [YEAR_W-1:0]  ref_year_q;
	logic [MONTH_W-1:0] ref_month_q;
	logic [DAY_W-1:0]   ref_day_q;

	logic [MONTH_W-1:0] ref_mon_norm;
	logic               ref_mon_hi;
	logic               ref_mon_lo;
	logic [YY_W-1:0]    ref_yy;
	logic [NUM_W-1:0]   ref_num_s3;

	line_t              line;
	logic               take_char;
	logic               take_end;

	logic               vld_s1, vld_s2, vld_s3;
	logic               ok_s1, ok_s2, ok_s3;
	logic [YEAR_W-1:0]  year_s1;
	logic [MONTH_W-1:0] month_s1;
	logic [DAY_W-1:0]   day_s1;
	logic [YY_W-1:0]    date_yy;
	logic [NUM_W-1:0]   date_num_s3;

	logic               rdy_out, rdy3, rdy2, rdy1;
	logic               result_valid_q;
	logic               date_valid_q;
	logic [GAP_W-1:0]   days_q;
	logic [NUM_W-1:0]   diff;
	logic               not_before;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_year_q  <= RESET_YEAR;
			ref_month_q <= RESET_MONTH;
			ref_day_q   <= RESET_DAY;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_YEAR:  ref_year_q  <= cfg_data[YEAR_W-1:0];
				REG_MONTH: ref_month_q <= cfg_data[MONTH_W-1:0];
				REG_DAY:   ref_day_q   <= cfg_data[DAY_W-1:0];
				default:   ;
			endcase
		end
	end

	// month roll-over of the reference
	assign ref_mon_hi   = ref_month_q > MONTHS_PER_YEAR;
	assign ref_mon_lo   = ref_month_q == 4'd0;
	assign ref_mon_norm = ref_mon_lo ? MONTHS_PER_YEAR :
	                      ref_mon_hi ? ref_month_q - MONTHS_PER_YEAR : ref_month_q;
	assign ref_yy = 15'(ref_year_q) + YEAR_BIAS + 15'(ref_mon_hi) - 15'(ref_mon_lo)
	              - 15'(ref_mon_norm <= 4'd2);

	dsdd_day_count u_ref_count (
		.clk    (clk),
		.en_a   (1'b1),
		.en_b   (1'b1),
		.yy     (ref_yy),
		.mp     (march_index(ref_mon_norm)),
		.day    (ref_day_q),
		.num_s3 (ref_num_s3)
	);

	// handshake and pipeline flow
	assign rdy_out    = !result_valid_q || result_ready;
	assign rdy3       = !vld_s3 || rdy_out;
	assign rdy2       = !vld_s2 || rdy3;
	assign rdy1       = !vld_s1 || rdy2;
	assign item_ready = rdy1;
	assign take_char  = item_valid && item_ready && !line_end;
	assign take_end   = item_valid && item_ready && line_end;

	dsdd_line_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take_char (take_char),
		.take_end  (take_end),
		.character (character),
		.line      (line)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_s3         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (rdy1)
				vld_s1 <= take_end;
			if (rdy2)
				vld_s2 <= vld_s1;
			if (rdy3)
				vld_s3 <= vld_s2;
			if (rdy_out)
				result_valid_q <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (take_end) begin
			ok_s1    <= line.ok;
			year_s1  <= line.year;
			month_s1 <= line.month;
			day_s1   <= line.day;
		end
		if (rdy2)
			ok_s2 <= ok_s1;
		if (rdy3)
			ok_s3 <= ok_s2;
	end

	assign date_yy = 15'(year_s1) + YEAR_BIAS - 15'(month_s1 <= 4'd2);

	dsdd_day_count u_date_count (
		.clk    (clk),
		.en_a   (rdy2),
		.en_b   (rdy3),
		.yy     (date_yy),
		.mp     (march_index(month_s1)),
		.day    (day_s1),
		.num_s3 (date_num_s3)
	);

	// compare against the reference and register the result
	assign diff       = date_num_s3 - ref_num_s3;
	assign not_before = date_num_s3 >= ref_num_s3;

	always_ff @(posedge clk) begin
		if (rdy_out && vld_s3) begin
			date_valid_q <= ok_s3 && not_before;
			days_q       <= (ok_s3 && not_before) ? diff[GAP_W-1:0] : '0;
		end
	end

	assign result_valid         = result_valid_q;
	assign date_valid           = date_valid_q;
	assign days_since_reference = days_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !date_valid |-> days_since_reference == '0)
		else $error("invalid result with nonzero day count");

	a_end_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && line_end |=> vld_s1)
		else $error("line-end transaction lost at pipeline entry");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		line.pos <= LINE_LENGTH)
		else $error("character position beyond line length");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> vld_s1 && vld_s2 && vld_s3 && result_valid && !result_ready)
		else $error("input stalled while pipeline has room");

endmodule
